// ===== rtl/core/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and constants of the multibrot escape-time colorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

    // Port field widths
    localparam int COORD_IN_W = 32;
    localparam int COUNT_OUT_W = 16;
    localparam int RGB_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Register widths
    localparam int RADIUS_W = 32;
    localparam int LIMIT_W = 16;
    localparam int EXP_W = 4;

    // Fixed-point format of the coordinates
    localparam int FRAC_BITS = 28;

    // Register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 32'h0400_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;
    localparam logic [EXP_W-1:0] EXP_RESET = 4'd2;
    localparam logic [EXP_W-1:0] EXP_MAX = 4'd8;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_LIMIT = 2'd1,
        CFG_EXPONENT = 2'd2
    } cfg_index_t;

    // Hue unit sizing: 100 * count fits 24 bits, root has 12 bits
    localparam int HUE_VW = 24;
    localparam int HUE_W = 12;
    localparam int HUE_Q_W = 7;
    localparam logic [HUE_VW-1:0] ROOT_TOP_BIT = 24'h40_0000;
    localparam logic [HUE_VW-1:0] HUE_SCALE = 24'd100;
    localparam int RECIP_60 = 1092;
    localparam int RECIP_SHIFT = 16;
    localparam logic [HUE_W-1:0] SECTOR_SPAN = 12'd60;
    localparam logic [HUE_Q_W-1:0] SECTOR_LAST = 7'd5;
    localparam logic [7:0] FULL_LEVEL = 8'd255;
    localparam logic [RGB_W-1:0] BLACK = 24'h00_0000;

    // Request to the hue unit
    typedef struct packed {
        logic start;
        logic [COUNT_OUT_W-1:0] count;
    } hue_req_t;

    // Response from the hue unit
    typedef struct packed {
        logic done;
        logic [RGB_W-1:0] rgb;
    } hue_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbet_ifs.sv =====
// ----------------------------------------------------------------------------
// mbet_ifs
// Valid/ready channels: point requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbet_point_if;
    import mbet_pkg::*;
    logic valid;
    logic ready;
    logic signed [COORD_IN_W-1:0] c_real;
    logic signed [COORD_IN_W-1:0] c_imag;
    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbet_result_if;
    import mbet_pkg::*;
    logic valid;
    logic ready;
    logic [COUNT_OUT_W-1:0] escape_count;
    logic [RGB_W-1:0] rgb_color;
    modport source (output valid, output escape_count, output rgb_color, input ready);
    modport sink (input valid, input escape_count, input rgb_color, output ready);
endinterface

interface mbet_cfg_if;
    import mbet_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mbet_hue.sv =====
// ----------------------------------------------------------------------------
// mbet_hue
// Maps an escape count to a hue ramp colour: bit-serial integer square root
// of 100*n, sector split by reciprocal multiply, then the sector ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_hue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mbet_pkg::hue_req_t req,
    output mbet_pkg::hue_rsp_t      rsp
);
    import mbet_pkg::*;

    typedef enum logic [2:0] {
        H_IDLE,
        H_ROOT,
        H_DIV_Q,
        H_DIV_R,
        H_RAMP
    } hstate_t;

    hstate_t state_reg, state_next;
    logic [HUE_VW-1:0] v_reg, v_next;
    logic [HUE_VW-1:0] res_reg, res_next;
    logic [HUE_VW-1:0] bit_reg, bit_next;
    logic [HUE_Q_W-1:0] q_reg, q_next;
    logic [2:0] sector_reg, sector_next;
    logic [5:0] m_reg, m_next;
    logic [RGB_W-1:0] rgb_reg, rgb_next;
    logic done_reg, done_next;

    logic [HUE_W-1:0] hue;
    logic [HUE_VW-1:0] trial;
    logic [HUE_W+10:0] q_prod;
    logic [HUE_W-1:0] rem;
    logic [HUE_Q_W-1:0] q_fix;
    logic [HUE_W-1:0] r_fix;
    logic [9:0] up_prod;
    logic [9:0] down_prod;
    logic [7:0] up;
    logic [7:0] down;

    assign hue = res_reg[HUE_W-1:0];
    assign trial = res_reg + bit_reg;
    assign q_prod = (HUE_W+11)'(hue) * (HUE_W+11)'(RECIP_60);
    assign rem = hue - HUE_W'(q_reg) * SECTOR_SPAN;
    assign up_prod = 10'(m_reg) * 10'd17;
    assign down_prod = (10'd60 - 10'(m_reg)) * 10'd17;
    assign up = up_prod[9:2];
    assign down = down_prod[9:2];

    // Correct the reciprocal quotient by at most one
    always_comb
    begin
        if (rem >= SECTOR_SPAN)
        begin
            q_fix = q_reg + 1'b1;
            r_fix = rem - SECTOR_SPAN;
        end
        else
        begin
            q_fix = q_reg;
            r_fix = rem;
        end
    end

    // Sequence the root, the split and the ramp
    always_comb
    begin
        state_next = state_reg;
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        q_next = q_reg;
        sector_next = sector_reg;
        m_next = m_reg;
        rgb_next = rgb_reg;
        done_next = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (req.start)
                begin
                    v_next = HUE_VW'(req.count) * HUE_SCALE;
                    res_next = '0;
                    bit_next = ROOT_TOP_BIT;
                    state_next = H_ROOT;
                end
            end
            H_ROOT:
            begin
                if (v_reg >= trial)
                begin
                    v_next = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = H_DIV_Q;
                end
            end
            H_DIV_Q:
            begin
                q_next = q_prod[RECIP_SHIFT +: HUE_Q_W];
                state_next = H_DIV_R;
            end
            H_DIV_R:
            begin
                sector_next = (q_fix > SECTOR_LAST) ? 3'(SECTOR_LAST) : 3'(q_fix);
                m_next = r_fix[5:0];
                state_next = H_RAMP;
            end
            H_RAMP:
            begin
                case (sector_reg)
                    3'd0:    rgb_next = {8'd0, up, FULL_LEVEL};
                    3'd1:    rgb_next = {8'd0, FULL_LEVEL, down};
                    3'd2:    rgb_next = {up, FULL_LEVEL, 8'd0};
                    3'd3:    rgb_next = {FULL_LEVEL, down, 8'd0};
                    3'd4:    rgb_next = {FULL_LEVEL, 8'd0, up};
                    default: rgb_next = {down, 8'd0, FULL_LEVEL};
                endcase
                done_next = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg <= 1'b0;
            v_reg <= '0;
            res_reg <= '0;
            bit_reg <= '0;
            q_reg <= '0;
            sector_reg <= '0;
            m_reg <= '0;
            rgb_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            v_reg <= v_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
            q_reg <= q_next;
            sector_reg <= sector_next;
            m_reg <= m_next;
            rgb_reg <= rgb_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rgb = rgb_reg;

`ifndef SYNTHESIS
    a_root_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == H_ROOT) |-> $onehot(bit_reg))
        else $error("root trial bit is not one-hot");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/multibrot_escape_time_colorizer.sv =====
// ----------------------------------------------------------------------------
// multibrot_escape_time_colorizer
// Escape-time iteration of z = z^p + c on one shared signed multiplier,
// followed by hue colouring of the escape count.
// ----------------------------------------------------------------------------
// Every passing test costs two squares plus four products per power step for
// exponent p, all issued one a cycle through the single multiplier.
// Throughput: one point at a time; the next request is taken once the result
// is in the output register. Asynchronous reset loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module multibrot_escape_time_colorizer
#(
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
)
(
    input wire logic     clk,
    input wire logic     rst_n,
    mbet_point_if.sink   pt,
    mbet_result_if.source res,
    mbet_cfg_if.sink     cfg
);
    import mbet_pkg::*;

    localparam int EFF = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int CNT_W = (COUNT_WIDTH >= 16) ? 16 : COUNT_WIDTH;
    localparam int PW = 2 * EFF;
    localparam int SHW = PW - FRAC_BITS;
    localparam int SUMW = ((SHW > EFF) ? SHW : EFF) + 1;
    localparam int ADDW = COORD_IN_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST_A,
        S_DIST_B,
        S_DIST_C,
        S_MUL_0,
        S_MUL_1,
        S_MUL_2,
        S_MUL_3,
        S_MUL_4,
        S_ADD,
        S_HUE_START,
        S_HUE_WAIT,
        S_DONE
    } state_t;

    // Configuration registers
    logic [RADIUS_W-1:0] radius_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [EXP_W-1:0] exp_reg;

    state_t state_reg, state_next;
    logic signed [COORD_IN_W-1:0] c_real_reg, c_real_next;
    logic signed [COORD_IN_W-1:0] c_imag_reg, c_imag_next;
    logic signed [EFF-1:0] z_real_reg, z_real_next;
    logic signed [EFF-1:0] z_imag_reg, z_imag_next;
    logic signed [EFF-1:0] rr_reg, rr_next;
    logic signed [EFF-1:0] ri_reg, ri_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic signed [SHW-1:0] t0_reg, t0_next;
    logic signed [SUMW-1:0] nr_reg, nr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0] pstep_reg, pstep_next;
    logic [RGB_W-1:0] rgb_reg, rgb_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic [RGB_W-1:0] out_rgb_reg, out_rgb_next;
    logic out_valid_reg, out_valid_next;

    logic signed [EFF-1:0] mul_a;
    logic signed [EFF-1:0] mul_b;
    logic signed [SHW-1:0] sh;
    logic signed [SUMW-1:0] ni_sum;
    logic nr_fits;
    logic ni_fits;
    logic signed [ADDW-1:0] add_r;
    logic signed [ADDW-1:0] add_i;
    logic add_fits;
    logic [PW:0] mag_sum;
    logic [64:0] dist_ext;
    logic [64:0] bound;
    logic [EXP_W-1:0] p_eff;
    logic [CNT_W-1:0] limit_eff;
    logic at_limit;
    logic more_steps;
    hue_req_t hue_req;
    hue_rsp_t hue_rsp;

    // Write configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            limit_reg <= LIMIT_RESET;
            exp_reg <= EXP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RADIUS:   radius_reg <= cfg.data[RADIUS_W-1:0];
                CFG_LIMIT:    limit_reg <= cfg.data[LIMIT_W-1:0];
                CFG_EXPONENT: exp_reg <= cfg.data[EXP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp the exponent and mask the limit
    assign p_eff = (exp_reg == '0) ? EXP_W'(1) : ((exp_reg > EXP_MAX) ? EXP_MAX : exp_reg);
    assign limit_eff = limit_reg[CNT_W-1:0];
    assign at_limit = (count_reg >= limit_eff);
    assign more_steps = ((EXP_W'(pstep_reg) + EXP_W'(2)) < p_eff);

    // Shared multiplier and floored product
    assign prod_next = mul_a * mul_b;
    assign sh = prod_reg[PW-1:FRAC_BITS];
    assign ni_sum = SUMW'(t0_reg) + SUMW'(sh);
    assign nr_fits = (&nr_reg[SUMW-1:EFF-1]) || !(|nr_reg[SUMW-1:EFF-1]);
    assign ni_fits = (&ni_sum[SUMW-1:EFF-1]) || !(|ni_sum[SUMW-1:EFF-1]);

    // Add c and check the coordinate range
    assign add_r = ADDW'(rr_reg) + ADDW'(c_real_reg);
    assign add_i = ADDW'(ri_reg) + ADDW'(c_imag_reg);
    assign add_fits = ((&add_r[ADDW-1:EFF-1]) || !(|add_r[ADDW-1:EFF-1]))
                   && ((&add_i[ADDW-1:EFF-1]) || !(|add_i[ADDW-1:EFF-1]));

    // Squared magnitude against the escape bound
    assign mag_sum = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign dist_ext = 65'(mag_sum);
    assign bound = 65'({radius_reg, 32'd0});

    // Sequence tests, power steps and colouring
    always_comb
    begin
        state_next = state_reg;
        c_real_next = c_real_reg;
        c_imag_next = c_imag_reg;
        z_real_next = z_real_reg;
        z_imag_next = z_imag_reg;
        rr_next = rr_reg;
        ri_next = ri_reg;
        acc_next = acc_reg;
        t0_next = t0_reg;
        nr_next = nr_reg;
        count_next = count_reg;
        pstep_next = pstep_reg;
        rgb_next = rgb_reg;
        out_count_next = out_count_reg;
        out_rgb_next = out_rgb_reg;
        out_valid_next = out_valid_reg && !res.ready;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pt.valid)
                begin
                    c_real_next = pt.c_real;
                    c_imag_next = pt.c_imag;
                    z_real_next = '0;
                    z_imag_next = '0;
                    count_next = '0;
                    pstep_next = '0;
                    state_next = S_DIST_A;
                end
            end
            S_DIST_A:
            begin
                mul_a = z_real_reg;
                mul_b = z_real_reg;
                state_next = S_DIST_B;
            end
            S_DIST_B:
            begin
                mul_a = z_imag_reg;
                mul_b = z_imag_reg;
                acc_next = prod_reg;
                state_next = S_DIST_C;
            end
            S_DIST_C:
            begin
                if (at_limit || !(dist_ext < bound))
                begin
                    state_next = S_HUE_START;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    rr_next = z_real_reg;
                    ri_next = z_imag_reg;
                    pstep_next = '0;
                    state_next = (p_eff == EXP_W'(1)) ? S_ADD : S_MUL_0;
                end
            end
            S_MUL_0:
            begin
                mul_a = z_real_reg;
                mul_b = rr_reg;
                state_next = S_MUL_1;
            end
            S_MUL_1:
            begin
                mul_a = z_imag_reg;
                mul_b = ri_reg;
                t0_next = sh;
                state_next = S_MUL_2;
            end
            S_MUL_2:
            begin
                mul_a = z_real_reg;
                mul_b = ri_reg;
                nr_next = SUMW'(t0_reg) - SUMW'(sh);
                state_next = S_MUL_3;
            end
            S_MUL_3:
            begin
                mul_a = rr_reg;
                mul_b = z_imag_reg;
                t0_next = sh;
                state_next = S_MUL_4;
            end
            S_MUL_4:
            begin
                if (!nr_fits || !ni_fits)
                begin
                    state_next = S_HUE_START;
                end
                else
                begin
                    rr_next = nr_reg[EFF-1:0];
                    ri_next = ni_sum[EFF-1:0];
                    pstep_next = pstep_reg + 1'b1;
                    state_next = more_steps ? S_MUL_0 : S_ADD;
                end
            end
            S_ADD:
            begin
                if (!add_fits)
                begin
                    state_next = S_HUE_START;
                end
                else
                begin
                    z_real_next = add_r[EFF-1:0];
                    z_imag_next = add_i[EFF-1:0];
                    state_next = S_DIST_A;
                end
            end
            S_HUE_START:
            begin
                state_next = S_HUE_WAIT;
            end
            S_HUE_WAIT:
            begin
                if (hue_rsp.done)
                begin
                    rgb_next = at_limit ? BLACK : hue_rsp.rgb;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_count_next = COUNT_OUT_W'(count_reg);
                    out_rgb_next = rgb_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg <= '0;
            pstep_reg <= '0;
            c_real_reg <= '0;
            c_imag_reg <= '0;
            z_real_reg <= '0;
            z_imag_reg <= '0;
            rr_reg <= '0;
            ri_reg <= '0;
            prod_reg <= '0;
            acc_reg <= '0;
            t0_reg <= '0;
            nr_reg <= '0;
            rgb_reg <= '0;
            out_count_reg <= '0;
            out_rgb_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg <= count_next;
            pstep_reg <= pstep_next;
            c_real_reg <= c_real_next;
            c_imag_reg <= c_imag_next;
            z_real_reg <= z_real_next;
            z_imag_reg <= z_imag_next;
            rr_reg <= rr_next;
            ri_reg <= ri_next;
            prod_reg <= prod_next;
            acc_reg <= acc_next;
            t0_reg <= t0_next;
            nr_reg <= nr_next;
            rgb_reg <= rgb_next;
            out_count_reg <= out_count_next;
            out_rgb_reg <= out_rgb_next;
        end
    end

    // Hue unit
    assign hue_req.start = (state_reg == S_HUE_START);
    assign hue_req.count = COUNT_OUT_W'(count_reg);

    mbet_hue u_hue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hue_req),
        .rsp   (hue_rsp)
    );

    // Drive the channels
    assign pt.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.escape_count = out_count_reg;
    assign res.rgb_color = out_rgb_reg;

`ifndef SYNTHESIS
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_hue_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        hue_rsp.done |-> (state_reg == S_HUE_WAIT))
        else $error("hue response arrived while not waiting");

    a_accept_starts_test: assert property (@(posedge clk) disable iff (!rst_n)
        (pt.valid && pt.ready) |=> (state_reg == S_DIST_A))
        else $error("accepted request did not start the escape test");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/multibrot_escape_time_colorizer_tb.sv =====
// ----------------------------------------------------------------------------
// multibrot_escape_time_colorizer_tb
// Feeds points through the escape-time colorizer and checks every result
// against an in-bench fixed-point iterator and hue mapper. Register
// settings change between phases, and both sides idle at random.
// ----------------------------------------------------------------------------

module multibrot_escape_time_colorizer_tb;

    import mbet_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 146;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic [RGB_W-1:0] rgb;
    } pixel_t;

    // Predict escape counts and colors, and match them to the results
    class pixel_scoreboard;
        logic [RADIUS_W-1:0] radius;
        logic [LIMIT_W-1:0] limit;
        logic [EXP_W-1:0] exponent;
        pixel_t expected_pixels[$];
        int mismatches;

        function new();
            radius = RADIUS_RESET;
            limit = LIMIT_RESET;
            exponent = EXP_RESET;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RADIUS: radius = data[RADIUS_W-1:0];
                CFG_LIMIT: limit = data[LIMIT_W-1:0];
                CFG_EXPONENT: exponent = data[EXP_W-1:0];
                default: ;
            endcase
        endfunction

        function bit coord_fits(longint v);
            return (v >= COORD_MIN) && (v <= COORD_MAX);
        endfunction

        function logic [RGB_W-1:0] hue_color(int unsigned n);
            int unsigned v, root, trial, sector, m, up, down;
            logic [7:0] r, g, b;
            if (n >= limit)
                return BLACK;
            // Integer square root of 100*n, one bit at a time
            v = n * HUE_SCALE;
            root = 0;
            for (int bt = 11; bt >= 0; bt--)
            begin
                trial = root | (1 << bt);
                if (trial * trial <= v)
                    root = trial;
            end
            sector = root / SECTOR_SPAN;
            if (sector > SECTOR_LAST)
                sector = SECTOR_LAST;
            m = root % SECTOR_SPAN;
            up = (m * 17) / 4;
            down = ((SECTOR_SPAN - m) * 17) / 4;
            case (sector)
                0: begin r = FULL_LEVEL; g = 8'(up); b = 8'd0; end
                1: begin r = 8'(down); g = FULL_LEVEL; b = 8'd0; end
                2: begin r = 8'd0; g = FULL_LEVEL; b = 8'(up); end
                3: begin r = 8'd0; g = 8'(down); b = FULL_LEVEL; end
                4: begin r = 8'(up); g = 8'd0; b = FULL_LEVEL; end
                default: begin r = FULL_LEVEL; g = 8'd0; b = 8'(down); end
            endcase
            return {b, g, r};
        endfunction

        function pixel_t predict_pixel(logic signed [COORD_IN_W-1:0] c_re,
                                       logic signed [COORD_IN_W-1:0] c_im);
            longint cr, ci, zr, zi, pr, pi, nr, ni;
            longint unsigned mag_sum, bound;
            int unsigned power, n;
            bit ok;
            pixel_t px;
            cr = c_re;
            ci = c_im;
            power = exponent;
            if (power == 0)
                power = 1;
            if (power > EXP_MAX)
                power = EXP_MAX;
            bound = {radius, 32'h0};
            zr = 0;
            zi = 0;
            n = 0;
            while (n < limit)
            begin
                mag_sum = zr * zr + zi * zi;
                if (mag_sum >= bound)
                    break;
                n++;
                // Raise z to the power by repeated complex products
                pr = zr;
                pi = zi;
                ok = 1'b1;
                for (int k = 1; k < power; k++)
                begin
                    nr = ((zr * pr) >>> FRAC_BITS) - ((zi * pi) >>> FRAC_BITS);
                    ni = ((zr * pi) >>> FRAC_BITS) + ((pr * zi) >>> FRAC_BITS);
                    if (!coord_fits(nr) || !coord_fits(ni))
                    begin
                        ok = 1'b0;
                        break;
                    end
                    pr = nr;
                    pi = ni;
                end
                // Add c; overflow anywhere stops the iteration as escaped
                if (ok)
                begin
                    nr = pr + cr;
                    ni = pi + ci;
                    if (!coord_fits(nr) || !coord_fits(ni))
                        ok = 1'b0;
                end
                if (!ok)
                    break;
                zr = nr;
                zi = ni;
            end
            px.count = n[COUNT_OUT_W-1:0];
            px.rgb = hue_color(n);
            return px;
        endfunction

        function void note_point(logic signed [COORD_IN_W-1:0] c_re,
                                 logic signed [COORD_IN_W-1:0] c_im);
            expected_pixels.push_back(predict_pixel(c_re, c_im));
        endfunction

        function void check_pixel(logic [COUNT_OUT_W-1:0] count, logic [RGB_W-1:0] rgb);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, count %0d color %06h", $time, count, rgb);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            if (count !== want.count)
            begin
                $display("%0t: escape_count expected %0d, actual %0d", $time, want.count, count);
                mismatches++;
            end
            if (rgb !== want.rgb)
            begin
                $display("%0t: rgb_color expected %06h, actual %06h", $time, want.rgb, rgb);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int send_idle;
    int recv_stall;
    int cycles;
    pixel_scoreboard board;

    mbet_point_if pt_if ();
    mbet_result_if res_if ();
    mbet_cfg_if cfg_if ();

    multibrot_escape_time_colorizer dut (
        .clk(clk),
        .rst_n(rst_n),
        .pt(pt_if),
        .res(res_if),
        .cfg(cfg_if)
    );

    // Clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle = 0; recv_stall = 0; end
            IDLE_SENDER: begin send_idle = 59; recv_stall = 0; end
            IDLE_RECEIVER: begin send_idle = 0; recv_stall = 59; end
            default: begin send_idle = 26; recv_stall = 26; end
        endcase
    endtask

    // Issue one point request; hold valid high until it is taken
    task automatic send_point(logic signed [COORD_IN_W-1:0] c_re,
                              logic signed [COORD_IN_W-1:0] c_im);
        while ($urandom_range(0, 99) < send_idle)
        begin
            pt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.c_real <= c_re;
        pt_if.c_imag <= c_im;
        @(posedge clk);
        while (!pt_if.ready)
            @(posedge clk);
        board.note_point(c_re, c_im);
    endtask

    // Drop valid and hold until every expected pixel is back
    task automatic wait_for_pixels();
        pt_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        board.set_register(idx, data);
    endtask

    // Write all registers; junk in the unused upper bits must be dropped
    task automatic configure(logic [RADIUS_W-1:0] radius, logic [LIMIT_W-1:0] limit,
                             logic [EXP_W-1:0] exponent);
        logic [CFG_DATA_W-1:0] limit_word, exp_word;
        limit_word = ($urandom & 32'hFFFF_0000) | limit;
        exp_word = ($urandom & 32'hFFFF_FFF0) | exponent;
        write_register(CFG_RADIUS, radius);
        write_register(CFG_LIMIT, limit_word);
        write_register(CFG_EXPONENT, exp_word);
        write_register(CFG_UNUSED, $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly points around the set, plus near-zero, full-range, extreme and cardioid-edge points
    task automatic random_point(output logic signed [COORD_IN_W-1:0] c_re,
                                output logic signed [COORD_IN_W-1:0] c_im);
        logic [COORD_IN_W-1:0] corners [5];
        corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                c_re = $urandom_range(0, 32'h5000_0000) - 32'h2800_0000;
                c_im = $urandom_range(0, 32'h5000_0000) - 32'h2800_0000;
            end
            6:
            begin
                c_re = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                c_im = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            end
            7:
            begin
                c_re = $urandom;
                c_im = $urandom;
            end
            8:
            begin
                c_re = corners[$urandom_range(0, 4)];
                c_im = corners[$urandom_range(0, 4)];
            end
            default:
            begin
                // Near the cardioid edge around -0.75, where counts run long
                c_re = 32'hF400_0000 + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
                c_im = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            end
        endcase
    endtask

    task automatic run_phase(logic [RADIUS_W-1:0] radius, logic [LIMIT_W-1:0] limit,
                             logic [EXP_W-1:0] exponent, idle_mode_t mode);
        logic signed [COORD_IN_W-1:0] c_re, c_im;
        wait_for_pixels();
        configure(radius, limit, exponent);
        set_idle(mode);
        repeat (PHASE_ITEMS)
        begin
            random_point(c_re, c_im);
            send_point(c_re, c_im);
            // Now and then hold off until the block has drained
            if ($urandom_range(0, 59) == 0)
                wait_for_pixels();
        end
    endtask

    // Result side: check accepted pixels, stall at random
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                board.check_pixel(res_if.escape_count, res_if.rgb_color);
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial
    begin
        board = new();
        send_idle = 0;
        recv_stall = 0;
        rst_n <= 1'b0;
        pt_if.valid <= 1'b0;
        pt_if.c_real <= '0;
        pt_if.c_imag <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_RADIUS;
        cfg_if.data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: points in, out, on the edge, and at the corners
        set_idle(IDLE_NONE);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'hF000_0000, 32'h0000_0000);
        send_point(32'h0400_0000, 32'h0000_0000);
        send_point(32'hE000_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h1000_0000);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        send_point(32'hF400_0000, 32'h0199_999A);
        send_point(32'h0500_0000, 32'h0900_0000);

        // Huge radius: escape only through overflow of a product or of the sum
        wait_for_pixels();
        configure(32'hFFFF_FFFF, 16'd8, 4'd2);
        set_idle(IDLE_BOTH);
        send_point(32'h2800_0000, 32'h0000_0000);
        send_point(32'h7E66_6666, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h2800_0000);
        send_point(32'hD800_0000, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h1000_0000, 32'h1000_0000);

        // Linear walk z = z + c: long counts reach several hue sectors and the cap
        wait_for_pixels();
        configure(32'h0400_0000, 16'd65535, 4'd1);
        set_idle(IDLE_SENDER);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'sd2684354, 32'sd0);
        send_point(32'sd0, -32'sd1073741);
        send_point(32'sd596523, 32'sd0);
        send_point(-32'sd357913, 32'sd0);

        // Random phases over a range of settings
        run_phase(32'h0400_0000, 16'd40, 4'd2, IDLE_NONE);
        run_phase(32'h0400_0000, 16'd20, 4'd3, IDLE_SENDER);
        run_phase(32'hFFFF_FFFF, 16'd12, 4'd9, IDLE_RECEIVER);
        run_phase(32'h0000_0000, 16'd65535, 4'd2, IDLE_BOTH);
        run_phase(32'h1000_0000, 16'd10, 4'd8, IDLE_NONE);
        run_phase(32'h0400_0000, 16'd1, 4'd0, IDLE_SENDER);
        run_phase(32'h0123_4567, 16'd0, 4'd15, IDLE_RECEIVER);
        run_phase(32'h0100_0000, 16'd64, 4'd1, IDLE_BOTH);

        wait_for_pixels();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mbet_pkg.sv
rtl/core/mbet_ifs.sv
rtl/core/mbet_hue.sv
rtl/core/multibrot_escape_time_colorizer.sv
tb/sv/multibrot_escape_time_colorizer_tb.sv
